// ===== sv/point_rotation_about_center_macros.svh =====
// assertion helpers shared by the rotation block
`ifndef POINT_ROTATION_ABOUT_CENTER_MACROS_SVH
`define POINT_ROTATION_ABOUT_CENTER_MACROS_SVH

// property that must hold in the same cycle
`define PRAC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// property that must hold in the cycle after the antecedent
`define PRAC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/prac_pkg.sv =====
package prac_pkg;

    localparam int ROTATION_STAGES = 16;
    localparam int TABLE_LEN       = 24;
    localparam int ROT_STAGES      = (ROTATION_STAGES > TABLE_LEN) ? TABLE_LEN : ROTATION_STAGES;

    localparam int COORD_W  = 24;
    localparam int ANGLE_W  = 16;
    localparam int DIFF_W   = COORD_W + 2;
    localparam int ACC_W    = 44;
    localparam int Z_W      = 32;
    localparam int GUARD    = 16;
    localparam int PRE_SH   = 30 - GUARD;
    localparam int IDX_W    = $clog2(TABLE_LEN);

    localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT  = 16'sd25736;
    localparam logic signed [ANGLE_W-1:0] HALF_PI_Q13  = 16'sd12868;
    localparam logic signed [Z_W-1:0]     PI_Q28       = 32'sd843314857;
    localparam logic signed [30:0]        GAIN_Q30     = 31'sd652032874;

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // folded difference vector and residual angle
    typedef struct packed {
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic signed [Z_W-1:0]     z;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
    } fold_t;

    // cordic working set
    typedef struct packed {
        logic signed [ACC_W-1:0]   x;
        logic signed [ACC_W-1:0]   y;
        logic signed [Z_W-1:0]     z;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
    } rot_t;

    // atan(2^-i) in q.28
    function automatic logic signed [Z_W-1:0] atan_q28(input logic [IDX_W-1:0] idx);
        logic signed [Z_W-1:0] r;
        case (idx)
            5'd0:    r = 32'sd210828714;
            5'd1:    r = 32'sd124459457;
            5'd2:    r = 32'sd65760959;
            5'd3:    r = 32'sd33381290;
            5'd4:    r = 32'sd16755422;
            5'd5:    r = 32'sd8385879;
            5'd6:    r = 32'sd4193963;
            5'd7:    r = 32'sd2097109;
            5'd8:    r = 32'sd1048571;
            5'd9:    r = 32'sd524287;
            5'd10:   r = 32'sd262144;
            5'd11:   r = 32'sd131072;
            5'd12:   r = 32'sd65536;
            5'd13:   r = 32'sd32768;
            5'd14:   r = 32'sd16384;
            5'd15:   r = 32'sd8192;
            5'd16:   r = 32'sd4096;
            5'd17:   r = 32'sd2048;
            5'd18:   r = 32'sd1024;
            5'd19:   r = 32'sd512;
            5'd20:   r = 32'sd256;
            5'd21:   r = 32'sd128;
            5'd22:   r = 32'sd64;
            5'd23:   r = 32'sd32;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/point_rotation_about_center.sv =====
// rotates a point about a center by a signed angle using a pipelined cordic
// pipeline: registers for fold, gain prescale, each cordic micro-rotation and
//   round/saturate; the result is registered in the last of them
// throughput: one transaction per cycle while m_tready is not held low; each register stage stalls on its own
// reset: rst_n asynchronous active low, clears the valid bits only
module point_rotation_about_center (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // point_x[23:0], point_y[47:24], center_x[71:48], center_y[95:72], angle[111:96]
    input  logic [111:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // rotated_x[23:0], rotated_y[47:24]
    output logic [47:0]  m_tdata,
    // overflow[0]
    output logic         m_tuser
);
    import prac_pkg::*;

    `include "point_rotation_about_center_macros.svh"

    logic signed [COORD_W-1:0] point_x, point_y, center_x, center_y;
    logic signed [ANGLE_W-1:0] angle;

    assign point_x  = s_tdata[23:0];
    assign point_y  = s_tdata[47:24];
    assign center_x = s_tdata[71:48];
    assign center_y = s_tdata[95:72];
    assign angle    = s_tdata[111:96];

    // ---------------- fold stage ----------------
    logic  fold_valid_reg;
    fold_t fold_reg;
    fold_t fold_next;
    logic  fold_ready;
    logic  pre_valid_reg;
    rot_t  pre_reg;
    rot_t  pre_next;
    logic  pre_ready;
    logic  rot_in_ready;
    logic  rot_out_valid;
    rot_t  rot_out;
    logic  out_ready;

    logic signed [DIFF_W-2:0]  dx_w, dy_w;
    logic signed [ANGLE_W-1:0] a_clamp;
    logic signed [Z_W-1:0]     z_w;

    always_comb
    begin
        dx_w = $signed({point_x[COORD_W-1], point_x}) - $signed({center_x[COORD_W-1], center_x});
        dy_w = $signed({point_y[COORD_W-1], point_y}) - $signed({center_y[COORD_W-1], center_y});
        if (angle > ANGLE_LIMIT)
            a_clamp = ANGLE_LIMIT;
        else if (angle < -ANGLE_LIMIT)
            a_clamp = -ANGLE_LIMIT;
        else
            a_clamp = angle;
        z_w = $signed({a_clamp[ANGLE_W-1], a_clamp, 15'b0});

        fold_next.cx = center_x;
        fold_next.cy = center_y;
        // outside plus or minus half pi: rotate by pi first
        if (a_clamp > HALF_PI_Q13)
        begin
            fold_next.dx = -$signed({dx_w[DIFF_W-2], dx_w});
            fold_next.dy = -$signed({dy_w[DIFF_W-2], dy_w});
            fold_next.z  = z_w - PI_Q28;
        end
        else if (a_clamp < -HALF_PI_Q13)
        begin
            fold_next.dx = -$signed({dx_w[DIFF_W-2], dx_w});
            fold_next.dy = -$signed({dy_w[DIFF_W-2], dy_w});
            fold_next.z  = z_w + PI_Q28;
        end
        else
        begin
            fold_next.dx = $signed({dx_w[DIFF_W-2], dx_w});
            fold_next.dy = $signed({dy_w[DIFF_W-2], dy_w});
            fold_next.z  = z_w;
        end
    end

    assign fold_ready = !fold_valid_reg || pre_ready;
    assign s_tready   = fold_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_valid_reg <= 1'b0;
        end
        else if (fold_ready)
        begin
            fold_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fold_ready && s_tvalid)
        begin
            fold_reg <= fold_next;
        end
    end

    // ---------------- gain prescale stage ----------------
    logic signed [DIFF_W+31-1:0] prod_x, prod_y;

    always_comb
    begin
        prod_x      = fold_reg.dx * GAIN_Q30;
        prod_y      = fold_reg.dy * GAIN_Q30;
        pre_next.x  = ACC_W'(prod_x >>> PRE_SH);
        pre_next.y  = ACC_W'(prod_y >>> PRE_SH);
        pre_next.z  = fold_reg.z;
        pre_next.cx = fold_reg.cx;
        pre_next.cy = fold_reg.cy;
    end

    assign pre_ready = !pre_valid_reg || rot_in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_valid_reg <= 1'b0;
        end
        else if (pre_ready)
        begin
            pre_valid_reg <= fold_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pre_ready && fold_valid_reg)
        begin
            pre_reg <= pre_next;
        end
    end

    // ---------------- cordic ----------------
    prac_rotator u_rotator (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pre_valid_reg),
        .in_data   (pre_reg),
        .in_ready  (rot_in_ready),
        .out_valid (rot_out_valid),
        .out_data  (rot_out),
        .out_ready (out_ready)
    );

    // ---------------- round, recenter, saturate ----------------
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (GUARD - 1);
    localparam int RND_W = ACC_W - GUARD;

    logic signed [RND_W-1:0] rnd_x, rnd_y;
    logic signed [RND_W:0]   sum_x, sum_y;
    logic                    out_valid_reg;
    logic signed [COORD_W-1:0] rx_reg, ry_reg, rx_next, ry_next;
    logic                    ovf_reg, ovf_next;

    always_comb
    begin
        rnd_x    = RND_W'((rot_out.x + ROUND_HALF) >>> GUARD);
        rnd_y    = RND_W'((rot_out.y + ROUND_HALF) >>> GUARD);
        sum_x    = $signed({rnd_x[RND_W-1], rnd_x}) + (RND_W+1)'(rot_out.cx);
        sum_y    = $signed({rnd_y[RND_W-1], rnd_y}) + (RND_W+1)'(rot_out.cy);
        ovf_next = 1'b0;
        if (sum_x > (RND_W+1)'(COORD_MAX))
        begin
            rx_next  = COORD_MAX;
            ovf_next = 1'b1;
        end
        else if (sum_x < (RND_W+1)'(COORD_MIN))
        begin
            rx_next  = COORD_MIN;
            ovf_next = 1'b1;
        end
        else
        begin
            rx_next = COORD_W'(sum_x);
        end
        if (sum_y > (RND_W+1)'(COORD_MAX))
        begin
            ry_next  = COORD_MAX;
            ovf_next = 1'b1;
        end
        else if (sum_y < (RND_W+1)'(COORD_MIN))
        begin
            ry_next  = COORD_MIN;
            ovf_next = 1'b1;
        end
        else
        begin
            ry_next = COORD_W'(sum_y);
        end
    end

    assign out_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= rot_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && rot_out_valid)
        begin
            rx_reg  <= rx_next;
            ry_reg  <= ry_next;
            ovf_reg <= ovf_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {ry_reg, rx_reg};
    assign m_tuser  = ovf_reg;

    // ---------------- checks ----------------
    `PRAC_ASSERT_NOW(a_ovf_saturated, m_tvalid && m_tuser,
        rx_reg == COORD_MAX || rx_reg == COORD_MIN || ry_reg == COORD_MAX || ry_reg == COORD_MIN,
        "overflow flagged without a saturated coordinate")
    `PRAC_ASSERT_NOW(a_empty_accepts, !m_tvalid, s_tready,
        "input stalled while the pipeline output is empty")
    `PRAC_ASSERT_NEXT(a_stall_holds_rot, m_tvalid && !m_tready && rot_out_valid,
        rot_out_valid && $stable(rot_out),
        "last cordic stage changed while the output was stalled")

endmodule

// ===== sv/prac_rotator.sv =====
module prac_rotator (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  prac_pkg::rot_t in_data,
    output logic           in_ready,
    output logic           out_valid,
    output prac_pkg::rot_t out_data,
    input  logic           out_ready
);
    import prac_pkg::*;

    logic [ROT_STAGES-1:0] valid_reg;
    rot_t                  data_reg [ROT_STAGES];
    logic [ROT_STAGES-1:0] stage_ready;

    for (genvar i = 0; i < ROT_STAGES; i++) begin : g_stage
        logic src_valid;
        rot_t src;
        rot_t data_next;
        logic signed [ACC_W-1:0] xs;
        logic signed [ACC_W-1:0] ys;
        logic down_ready;

        if (i == 0) begin : g_first
            assign src_valid = in_valid;
            assign src       = in_data;
        end
        else begin : g_mid
            assign src_valid = valid_reg[i-1];
            assign src       = data_reg[i-1];
        end

        if (i == ROT_STAGES - 1) begin : g_last
            assign down_ready = out_ready;
        end
        else begin : g_next
            assign down_ready = stage_ready[i+1];
        end

        assign stage_ready[i] = !valid_reg[i] || down_ready;

        // one micro-rotation, both updates from the previous values
        always_comb
        begin
            xs        = src.x >>> i;
            ys        = src.y >>> i;
            data_next = src;
            if (src.z >= 0)
            begin
                data_next.x = src.x - ys;
                data_next.y = src.y + xs;
                data_next.z = src.z - atan_q28(IDX_W'(i));
            end
            else
            begin
                data_next.x = src.x + ys;
                data_next.y = src.y - xs;
                data_next.z = src.z + atan_q28(IDX_W'(i));
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (stage_ready[i])
            begin
                valid_reg[i] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (stage_ready[i] && src_valid)
            begin
                data_reg[i] <= data_next;
            end
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[ROT_STAGES-1];
    assign out_data  = data_reg[ROT_STAGES-1];

endmodule

// ===== verif/tb_point_rotation_about_center.sv =====
module tb_point_rotation_about_center;
    timeunit 1ns;
    timeprecision 1ps;

    import prac_pkg::*;

    localparam int     CYCLE_LIMIT  = 200000;
    localparam int     DRAIN_CYCLES = 40;
    localparam int     RANDOM_ITEMS = 1300;
    localparam longint ANGLE_MAX    = 25736;
    localparam longint QUARTER_TURN = 12868;
    localparam longint PI_Q28_VAL   = 843314857;
    localparam longint GAIN_Q30_VAL = 652032874;
    localparam longint COORD_HI     = 8388607;
    localparam longint COORD_LO     = -8388608;
    localparam int     C_MAX        = 8388607;
    localparam int     C_MIN        = -8388608;

    // atan(2^-i) in q.28
    localparam longint ATAN_STEP [0:23] = '{
        210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
        4193963, 2097109, 1048571, 524287, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048,
        1024, 512, 256, 128, 64, 32
    };

    // packed so that point_x lands in the lowest bits of s_tdata
    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_x;
    } rot_request_t;

    typedef struct packed {
        logic                      overflow;
        logic signed [COORD_W-1:0] rot_y;
        logic signed [COORD_W-1:0] rot_x;
    } rot_point_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    rot_request_t s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [47:0]  m_tdata;
    logic         m_tuser;

    rot_request_t pending_requests[$];
    rot_point_t   expected_points[$];
    int           mismatches = 0;
    int           total_requests = 0;
    int           accepted_requests = 0;
    int           results_seen = 0;
    int           cycles = 0;
    logic         req_taken = 1'b0;
    int           burst_left = 1;
    int           gap_left = 0;
    int           driven_count = 0;
    int           stall_left = 0;

    point_rotation_about_center uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic rot_point_t rotate_about_center(input rot_request_t req);
        longint     dx;
        longint     dy;
        longint     ang;
        longint     z;
        longint     x;
        longint     y;
        longint     xs;
        longint     ys;
        longint     rx;
        longint     ry;
        int         n;
        rot_point_t res;
        dx  = longint'(req.point_x) - longint'(req.center_x);
        dy  = longint'(req.point_y) - longint'(req.center_y);
        ang = longint'(req.angle);
        if (ang > ANGLE_MAX)
            ang = ANGLE_MAX;
        if (ang < -ANGLE_MAX)
            ang = -ANGLE_MAX;
        z = ang * 32768;
        // fold rotations past a quarter turn by flipping the vector
        if (ang > QUARTER_TURN)
        begin
            dx = -dx;
            dy = -dy;
            z  = z - PI_Q28_VAL;
        end
        else if (ang < -QUARTER_TURN)
        begin
            dx = -dx;
            dy = -dy;
            z  = z + PI_Q28_VAL;
        end
        x = (dx * GAIN_Q30_VAL) >>> 14;
        y = (dy * GAIN_Q30_VAL) >>> 14;
        n = (ROT_STAGES > 24) ? 24 : ROT_STAGES;
        for (int i = 0; i < n; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_STEP[i];
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_STEP[i];
            end
        end
        rx = ((x + 32768) >>> 16) + longint'(req.center_x);
        ry = ((y + 32768) >>> 16) + longint'(req.center_y);
        res.overflow = 1'b0;
        if (rx > COORD_HI)
        begin
            rx = COORD_HI;
            res.overflow = 1'b1;
        end
        else if (rx < COORD_LO)
        begin
            rx = COORD_LO;
            res.overflow = 1'b1;
        end
        if (ry > COORD_HI)
        begin
            ry = COORD_HI;
            res.overflow = 1'b1;
        end
        else if (ry < COORD_LO)
        begin
            ry = COORD_LO;
            res.overflow = 1'b1;
        end
        res.rot_x = rx[COORD_W-1:0];
        res.rot_y = ry[COORD_W-1:0];
        return res;
    endfunction

    function automatic rot_request_t make_request(input int px, input int py, input int cx,
                                                  input int cy, input int ang);
        rot_request_t r;
        r.point_x  = px[COORD_W-1:0];
        r.point_y  = py[COORD_W-1:0];
        r.center_x = cx[COORD_W-1:0];
        r.center_y = cy[COORD_W-1:0];
        r.angle    = ang[ANGLE_W-1:0];
        return r;
    endfunction

    function automatic int rand_span(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("result %0d: %s is %0d, expected %0d", results_seen, what, got, want);
        mismatches++;
    endtask

    task automatic queue_request(input rot_request_t r);
        pending_requests.push_back(r);
        total_requests++;
    endtask

    // driver: bursts of random length separated by random gaps
    always @(negedge clk)
    begin
        logic         nv;
        rot_request_t nd;
        nv = s_tvalid;
        nd = s_tdata;
        if (rst_n && (!s_tvalid || req_taken))
        begin
            nv = 1'b0;
            if (gap_left > 0)
                gap_left--;
            else if (pending_requests.size() > 0)
            begin
                nd = pending_requests.pop_front();
                nv = 1'b1;
                driven_count++;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    // stretches without gaps now and then
                    if ((driven_count % 400) >= 300)
                        gap_left = 0;
                    else
                        gap_left = $urandom_range(1, 6);
                end
            end
        end
        s_tvalid <= nv;
        s_tdata  <= nd;
    end

    // receiver back-pressure on its own pattern
    always @(negedge clk)
    begin
        logic rdy;
        if (stall_left > 0)
        begin
            stall_left--;
            rdy = 1'b0;
        end
        else if ((cycles % 3000) < 2200 && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 7);
            rdy = 1'b0;
        end
        else
            rdy = 1'b1;
        m_tready <= rdy;
    end

    always @(posedge clk)
    begin
        rot_point_t want;
        rot_point_t got;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            req_taken <= s_tvalid && s_tready;
            if (rst_n && s_tvalid && s_tready)
            begin
                expected_points.push_back(rotate_about_center(s_tdata));
                accepted_requests++;
            end
            if (rst_n && m_tvalid && m_tready)
            begin
                got = {m_tuser, m_tdata};
                if (expected_points.size() == 0)
                    report_mismatch("unexpected transaction, rotated_x",
                                    longint'(got.rot_x), longint'(0));
                else
                begin
                    want = expected_points.pop_front();
                    if (got.rot_x !== want.rot_x)
                        report_mismatch("rotated_x", longint'(got.rot_x),
                                        longint'(want.rot_x));
                    if (got.rot_y !== want.rot_y)
                        report_mismatch("rotated_y", longint'(got.rot_y),
                                        longint'(want.rot_y));
                    if (got.overflow !== want.overflow)
                        report_mismatch("overflow", longint'(got.overflow),
                                        longint'(want.overflow));
                end
                results_seen++;
            end
        end
    end

    initial
    begin
        int kind;
        int cx;
        int cy;
        int ang;
        rot_request_t r;
        int boundary [0:8];
        boundary = '{0, 12868, -12868, 12869, -12869, 25736, -25736, 25735, -25735};

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_request(make_request(256, 0, 0, 0, 0));
        queue_request(make_request(256, 0, 0, 0, 12868));
        queue_request(make_request(256, 0, 0, 0, -12868));
        queue_request(make_request(256, 0, 0, 0, 12869));
        queue_request(make_request(256, 0, 0, 0, -12869));
        queue_request(make_request(256, 512, 0, 0, 25736));
        queue_request(make_request(256, 512, 0, 0, -25736));
        // angles beyond pi clamp
        queue_request(make_request(256, 512, 0, 0, 32767));
        queue_request(make_request(256, 512, 0, 0, -32768));
        queue_request(make_request(C_MAX, C_MAX, 0, 0, 6434));
        queue_request(make_request(C_MIN, C_MIN, 0, 0, -6434));
        queue_request(make_request(C_MAX, 0, C_MIN, 0, 25736));
        queue_request(make_request(C_MIN, C_MIN, C_MAX, C_MAX, 25736));
        queue_request(make_request(C_MAX, C_MAX, C_MAX, C_MAX, 12868));
        queue_request(make_request(1000, -2000, 500, 300, 3000));
        queue_request(make_request(0, 0, 0, 0, -1));
        queue_request(make_request(-1, -1, 0, 0, 1));
        queue_request(make_request(C_MIN, C_MAX, 0, 0, 0));
        queue_request(make_request(C_MAX, C_MIN, C_MIN, C_MAX, -12868));
        queue_request(make_request(100, 100, -100, -100, 25735));

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            kind = $urandom_range(0, 9);
            ang  = rand_span(25736);
            if (kind <= 3)
            begin
                cx = rand_span(1 << 20);
                cy = rand_span(1 << 20);
                r = make_request(cx + rand_span(1 << 16), cy + rand_span(1 << 16), cx, cy, ang);
            end
            else if (kind <= 5)
                r = make_request(rand_span(1 << 22), rand_span(1 << 22), 0, 0, ang);
            else if (kind == 6)
            begin
                r.point_x  = COORD_W'($urandom);
                r.point_y  = COORD_W'($urandom);
                r.center_x = COORD_W'($urandom);
                r.center_y = COORD_W'($urandom);
                r.angle    = ANGLE_W'($urandom);
            end
            else if (kind == 7)
            begin
                // wide differences that often saturate
                r = make_request(rand_span(C_MAX), rand_span(C_MAX),
                                 rand_span(C_MAX), rand_span(C_MAX), ang);
            end
            else if (kind == 8)
            begin
                ang = boundary[$urandom_range(0, 8)] + rand_span(2);
                r = make_request(rand_span(1 << 18), rand_span(1 << 18),
                                 rand_span(1 << 10), rand_span(1 << 10), ang);
            end
            else
            begin
                r = make_request(rand_span(C_MAX), rand_span(C_MAX),
                                 rand_span(1 << 12), rand_span(1 << 12), 0);
                r.angle = ANGLE_W'($urandom);
            end
            queue_request(r);
        end

        while (accepted_requests < total_requests || expected_points.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0 && expected_points.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/prac_pkg.sv
sv/prac_rotator.sv
sv/point_rotation_about_center.sv
verif/tb_point_rotation_about_center.sv
